// ----- design/sddc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_pkg
// Shared types, constants and register codes for the debounce event counter.
// ----------------------------------------------------------------------------
package sddc_pkg;

    localparam int CHANNELS_DEF   = 2;
    localparam int TIME_BITS_DEF  = 32;

    localparam int NOW_W          = 32;
    localparam int HOUR_W         = 5;
    localparam int MINUTE_W       = 6;
    localparam int COUNT_W        = 32;
    localparam int INTERVAL_W     = 16;
    localparam int DAYMIN_W       = 11;   // 31*60+63 fits
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [DAYMIN_W-1:0] MIN_PER_HOUR = DAYMIN_W'(60);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_EN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOUR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MINUTE  = 3'd6;

    typedef struct packed {
        logic [INTERVAL_W-1:0] debounce_interval_ms;
        logic                  active_low;
        logic                  schedule_enabled;
        logic [HOUR_W-1:0]     start_hour;
        logic [MINUTE_W-1:0]   start_minute;
        logic [HOUR_W-1:0]     stop_hour;
        logic [MINUTE_W-1:0]   stop_minute;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        debounce_interval_ms: INTERVAL_W'(50),
        active_low:           1'b1,
        schedule_enabled:     1'b0,
        start_hour:           HOUR_W'(7),
        start_minute:         MINUTE_W'(0),
        stop_hour:            HOUR_W'(16),
        stop_minute:          MINUTE_W'(0)
    };

    typedef struct packed {
        logic [COUNT_W-1:0] event_count;
        logic               counted;
        logic               window_open;
    } t_result;

    // per-tick control handed from the gate/lanes to the merging stage
    typedef struct packed {
        logic accept;
        logic clear;
        logic window_open;
    } t_tick_ctl;

endpackage

// ----- design/sddc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_if
// Valid/ready channels for sample ticks, results and register writes.
// ----------------------------------------------------------------------------
interface sddc_in_if;
    logic                            valid;
    logic                            ready;
    logic [sddc_pkg::NOW_W-1:0]      now_ms;
    logic                            switch_a_level;
    logic                            switch_b_level;
    logic [sddc_pkg::HOUR_W-1:0]     hour_of_day;
    logic [sddc_pkg::MINUTE_W-1:0]   minute_of_hour;
    logic                            clear_count;

    modport source (output valid, now_ms, switch_a_level, switch_b_level, hour_of_day,
                    minute_of_hour, clear_count, input ready);
    modport sink   (input valid, now_ms, switch_a_level, switch_b_level, hour_of_day,
                    minute_of_hour, clear_count, output ready);
endinterface

interface sddc_out_if;
    logic                            valid;
    logic                            ready;
    logic [sddc_pkg::COUNT_W-1:0]    event_count;
    logic                            counted;
    logic                            window_open;

    modport source (output valid, event_count, counted, window_open, input ready);
    modport sink   (input valid, event_count, counted, window_open, output ready);
endinterface

interface sddc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sddc_pkg::CFG_IDX_W-1:0]    index;
    logic [sddc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/sddc_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_window
// Time-of-day gate; a window whose start is after its stop wraps midnight.
// ----------------------------------------------------------------------------
module sddc_window (
    input  sddc_pkg::t_cfg                   i_cfg,
    input  logic [sddc_pkg::HOUR_W-1:0]      i_hour,
    input  logic [sddc_pkg::MINUTE_W-1:0]    i_minute,
    output logic                             o_open
);

    logic [sddc_pkg::DAYMIN_W-1:0] w_t;
    logic [sddc_pkg::DAYMIN_W-1:0] w_s;
    logic [sddc_pkg::DAYMIN_W-1:0] w_e;

    assign w_t = sddc_pkg::DAYMIN_W'(i_hour) * sddc_pkg::MIN_PER_HOUR
               + sddc_pkg::DAYMIN_W'(i_minute);
    assign w_s = sddc_pkg::DAYMIN_W'(i_cfg.start_hour) * sddc_pkg::MIN_PER_HOUR
               + sddc_pkg::DAYMIN_W'(i_cfg.start_minute);
    assign w_e = sddc_pkg::DAYMIN_W'(i_cfg.stop_hour) * sddc_pkg::MIN_PER_HOUR
               + sddc_pkg::DAYMIN_W'(i_cfg.stop_minute);

    always_comb begin
        if (!i_cfg.schedule_enabled) begin
            o_open = 1'b1;
        end else if (w_s <= w_e) begin
            o_open = (w_t >= w_s) && (w_t < w_e);
        end else begin
            o_open = (w_t >= w_s) || (w_t < w_e);
        end
    end

endmodule

// ----- design/sddc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_lane
// One switch channel: settle timer, stable level and activation detect.
// ----------------------------------------------------------------------------
module sddc_lane #(
    parameter int TIME_BITS = sddc_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_raw,
    input  logic [sddc_pkg::NOW_W-1:0]         i_now,
    input  logic [sddc_pkg::INTERVAL_W-1:0]    i_interval,
    input  logic                               i_active_level,
    output logic                               o_hit
);

    logic                 r_settle;
    logic                 r_stable;
    logic [TIME_BITS-1:0] r_last;
    logic                 n_settle;
    logic                 n_stable;
    logic [TIME_BITS-1:0] n_last;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_update;

    assign w_now = TIME_BITS'(i_now);

    always_comb begin
        n_settle = r_settle;
        n_last   = r_last;
        if (i_raw != r_settle) begin
            n_settle = i_raw;
            n_last   = w_now;
        end
        // a fresh change gives zero elapsed time, so it never promotes at once
        w_elapsed = w_now - n_last;
        w_update  = (w_elapsed > TIME_BITS'(i_interval)) && (n_settle != r_stable);
        n_stable  = w_update ? n_settle : r_stable;
        o_hit     = i_en && w_update && (n_settle == i_active_level);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 1'b1;
            r_stable <= 1'b1;
            r_last   <= '0;
        end else if (i_en) begin
            r_settle <= n_settle;
            r_stable <= n_stable;
            r_last   <= n_last;
        end
    end

endmodule

// ----- design/sddc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_merge
// Combines lane activations into the event count; two-entry result buffer.
// ----------------------------------------------------------------------------
module sddc_merge #(
    parameter int CHANNELS = sddc_pkg::CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sddc_pkg::t_tick_ctl       i_ctl,
    input  logic [CHANNELS-1:0]       i_hits,
    output logic                      o_in_ready,
    output logic                      o_valid,
    input  logic                      i_ready,
    output sddc_pkg::t_result         o_result
);

    logic [sddc_pkg::COUNT_W-1:0] r_count;
    logic [sddc_pkg::COUNT_W-1:0] n_count;
    logic                         w_hit;
    logic                         w_pop;
    sddc_pkg::t_result            w_new;
    sddc_pkg::t_result            r_out;
    sddc_pkg::t_result            r_skid;
    logic                         r_out_valid;
    logic                         r_skid_valid;

    assign w_hit = |i_hits;

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (w_hit) begin
            n_count = r_count + 1'b1;
        end
        w_new.event_count = n_count;
        w_new.counted     = w_hit && !i_ctl.clear;
        w_new.window_open = i_ctl.window_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.accept) begin
            r_count <= n_count;
        end
    end

    assign w_pop      = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    // head register plus skid entry; a request is only taken while skid is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_ctl.accept) begin
                    r_skid <= w_new;
                end else begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_ctl.accept) begin
                r_out <= w_new;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_ctl.accept) begin
            if (!r_out_valid) begin
                r_out       <= w_new;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_new;
                r_skid_valid <= 1'b1;
            end
        end
    end

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a head result");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && i_ctl.clear) |=> (r_count == '0))
        else $error("clear did not zero the count");

    a_hit_increments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && !i_ctl.clear && w_hit)
            |=> (r_count == $past(r_count) + 1'b1))
        else $error("activation did not advance the count");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.accept |=> $stable(r_count))
        else $error("count moved without a request");

endmodule

// ----- design/scheduled_dual_switch_debounce_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_dual_switch_debounce_counter
// Debounces switch channels in parallel lanes and counts activations, gated
// by a time-of-day window.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload                                      Handshake
//  i_in      in    now_ms, switch levels, hour, minute, clear   valid/ready
//  o_out     out   event_count, counted, window_open            valid/ready
//  i_cfg     in    index (3b), data (16b)                       valid/ready
//
//  One request per cycle while i_in.ready is high. Lane state and count update
//  as the request is taken and its result is registered; a two-entry output
//  buffer lets one further request in while a result waits.
//  i_in.ready drops only when both output entries are full.
//  Reset (i_rst_n low, synchronous) restores register defaults, sets levels
//  high, timestamps and count to zero and empties the output buffer.
//  Register writes are always taken.
// ----------------------------------------------------------------------------
module scheduled_dual_switch_debounce_counter #(
    parameter int CHANNELS  = sddc_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = sddc_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sddc_in_if.sink     i_in,
    sddc_out_if.source  o_out,
    sddc_cfg_if.sink    i_cfg
);

    sddc_pkg::t_cfg      r_cfg;
    sddc_pkg::t_tick_ctl w_ctl;
    sddc_pkg::t_result   w_result;
    logic                w_in_ready;
    logic                w_open;
    logic                w_accept;
    logic [CHANNELS-1:0] w_raw;
    logic [CHANNELS-1:0] w_hits;

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sddc_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sddc_pkg::CFG_DEBOUNCE:     r_cfg.debounce_interval_ms <= i_cfg.data;
                sddc_pkg::CFG_ACTIVE_LOW:   r_cfg.active_low <= i_cfg.data[0];
                sddc_pkg::CFG_SCHED_EN:     r_cfg.schedule_enabled <= i_cfg.data[0];
                sddc_pkg::CFG_START_HOUR:
                    r_cfg.start_hour <= i_cfg.data[sddc_pkg::HOUR_W-1:0];
                sddc_pkg::CFG_START_MINUTE:
                    r_cfg.start_minute <= i_cfg.data[sddc_pkg::MINUTE_W-1:0];
                sddc_pkg::CFG_STOP_HOUR:
                    r_cfg.stop_hour <= i_cfg.data[sddc_pkg::HOUR_W-1:0];
                sddc_pkg::CFG_STOP_MINUTE:
                    r_cfg.stop_minute <= i_cfg.data[sddc_pkg::MINUTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    sddc_window u_window (
        .i_cfg    (r_cfg),
        .i_hour   (i_in.hour_of_day),
        .i_minute (i_in.minute_of_hour),
        .o_open   (w_open)
    );

    // channels beyond the two switch inputs idle high
    always_comb begin
        w_raw    = '1;
        w_raw[0] = i_in.switch_a_level;
        if (CHANNELS > 1) begin
            w_raw[CHANNELS > 1 ? 1 : 0] = i_in.switch_b_level;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        sddc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_en           (w_accept && w_open),
            .i_raw          (w_raw[g]),
            .i_now          (i_in.now_ms),
            .i_interval     (r_cfg.debounce_interval_ms),
            .i_active_level (!r_cfg.active_low),
            .o_hit          (w_hits[g])
        );
    end

    assign w_ctl.accept      = w_accept;
    assign w_ctl.clear       = i_in.clear_count;
    assign w_ctl.window_open = w_open;

    sddc_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_hits     (w_hits),
        .o_in_ready (w_in_ready),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (w_result)
    );

    assign o_out.event_count = w_result.event_count;
    assign o_out.counted     = w_result.counted;
    assign o_out.window_open = w_result.window_open;

endmodule
